// ----- sv/cli_pkg.sv -----
// Shared types, constants and width helpers for the conic/line intersection block.
// Depends on nothing; every other file but cli_fifo imports it.
package cli_pkg;

  localparam int DW    = 32;
  localparam int THR_W = 32;
  localparam int CHUNK = 32;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_COMPLEX = 2'd1,
    ST_ZERO_A  = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  typedef struct packed {
    logic                 mode;
    logic signed [DW-1:0] conic_xx;
    logic signed [DW-1:0] conic_xy;
    logic signed [DW-1:0] conic_xw;
    logic signed [DW-1:0] conic_yy;
    logic signed [DW-1:0] conic_yw;
    logic signed [DW-1:0] conic_ww;
    logic signed [DW-1:0] line_coord;
  } cli_in_t;

  typedef struct packed {
    logic signed [DW-1:0] root_plus;
    logic signed [DW-1:0] root_minus;
    status_t              status;
  } cli_out_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // linear coefficient b, 2F fraction bits
  function automatic int wb_w(input int f);
    return imax(2 * DW, DW + f) + 2;
  endfunction

  // the two lower terms of c, 3F fraction bits
  function automatic int wcq_w(input int f);
    return imax(2 * DW + f + 1, DW + 2 * f) + 1;
  endfunction

  function automatic int wc_w(input int f);
    return imax(3 * DW, wcq_w(f)) + 1;
  endfunction

  // discriminant, 4F fraction bits
  function automatic int wds_w(input int f);
    return imax(2 * wb_w(f), DW + wc_w(f) + 2) + 1;
  endfunction

  function automatic int wsq_w(input int f);
    return wds_w(f) / 2;
  endfunction

  // root numerators -b +/- sqrt
  function automatic int wn_w(input int f);
    return imax(wb_w(f), wsq_w(f) + 1) + 1;
  endfunction

endpackage

// ----- sv/cli_mul.sv -----
// Pipelined signed multiplier built from 32x32 partial products, four stages.
// Carries a valid bit and a sideband word alongside; uses cli_pkg.
module cli_mul
  import cli_pkg::*;
#(
  parameter int WA  = 32,
  parameter int WBB = 32,
  parameter int SW  = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic signed [WA-1:0]      a,
  input  logic signed [WBB-1:0]     b,
  input  logic [SW-1:0]             side_in,
  output logic                      out_vld,
  output logic signed [WA+WBB-1:0]  p,
  output logic [SW-1:0]             side_out
);

  localparam int NA = (WA + CHUNK - 1) / CHUNK;
  localparam int NB = (WBB + CHUNK - 1) / CHUNK;
  localparam int WP = WA + WBB;

  logic [3:0]          v_r;
  logic [SW-1:0]       s1_r, s2_r, s3_r, s4_r;
  logic                ng1_r, ng2_r, ng3_r;
  logic [NA*CHUNK-1:0] am_r;
  logic [NB*CHUNK-1:0] bm_r;
  logic [2*CHUNK-1:0]  pp_r [NA*NB];
  logic [WP-1:0]       sum_r;
  logic signed [WP-1:0] p_r;
  logic [WA-1:0]       a_mag;
  logic [WBB-1:0]      b_mag;
  logic [WP-1:0]       sum_nxt;

  assign a_mag = a[WA-1] ? WA'(-a) : WA'(a);
  assign b_mag = b[WBB-1] ? WBB'(-b) : WBB'(b);

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_nxt = sum_nxt + (WP'(pp_r[i*NB+j]) << ((i + j) * CHUNK));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r  <= (NA*CHUNK)'(a_mag);
      bm_r  <= (NB*CHUNK)'(b_mag);
      ng1_r <= a[WA-1] ^ b[WBB-1];
      s1_r  <= side_in;
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i*NB+j] <= am_r[i*CHUNK +: CHUNK] * bm_r[j*CHUNK +: CHUNK];
        end
      end
      ng2_r <= ng1_r;
      s2_r  <= s1_r;
      sum_r <= sum_nxt;
      ng3_r <= ng2_r;
      s3_r  <= s2_r;
      p_r   <= ng3_r ? -$signed(sum_r) : $signed(sum_r);
      s4_r  <= s3_r;
    end
  end

  assign out_vld  = v_r[3];
  assign p        = p_r;
  assign side_out = s4_r;

endmodule

// ----- sv/cli_fifo.sv -----
// Small register-based queue with a registered head entry and a fill count.
// Used between the front and back halves and at the result side; imports nothing.
module cli_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

// ----- sv/cli_front.sv -----
// Front half: forms the quadratic, the exact discriminant and the item class.
// Built from cli_mul instances; uses cli_pkg.
module cli_front
  import cli_pkg::*;
#(
  parameter  int FRAC_BITS = 16,
  localparam int WB  = wb_w(FRAC_BITS),
  localparam int WDS = wds_w(FRAC_BITS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_acc,
  input  cli_in_t               in_item,
  input  logic [THR_W-1:0]      thr,
  input  logic                  mid_full,
  output logic                  fe,
  output logic                  mid_push,
  output logic signed [WB-1:0]  mid_b,
  output logic signed [DW-1:0]  mid_a,
  output logic signed [WDS-1:0] mid_disc,
  output status_t               mid_cls
);

  localparam int WCQ = wcq_w(FRAC_BITS);
  localparam int WC  = wc_w(FRAC_BITS);
  localparam int WT  = imax(WDS, THR_W + 2 * FRAC_BITS);
  localparam int S4W = DW + WB + WCQ;

  logic signed [DW-1:0]   a_sel, q_sel, rq_sel, sq_sel;
  logic                   v1, v4, v6;
  logic signed [2*DW-1:0] p_bt, p_rt, p_st;
  logic [DW-1:0]          q_d, t_d;
  logic [2*DW-1:0]        s3_d;
  logic signed [WB-1:0]   b_c;
  logic signed [WCQ-1:0]  cq_c;
  logic signed [3*DW-1:0] p_rtt;
  logic [S4W-1:0]         s4_d;
  logic signed [2*WB-1:0] bb;
  logic signed [DW+WC-1:0] ac;
  logic [DW-1:0]          s5_d;
  logic [WB-1:0]          s6_d;

  logic                   vc_r, vd_r, ve_r;
  logic signed [WC-1:0]   c_r;
  logic signed [WB-1:0]   bc_r, bd_r, be_r;
  logic signed [DW-1:0]   ac_r, ad_r, ae_r;
  logic signed [WDS-1:0]  disc_r, disce_r;
  logic [WDS-1:0]         absd_r;
  logic [WT-1:0]          thr_sh;
  logic                   tiny;

  assign fe = !mid_full || !ve_r;

  assign a_sel  = in_item.mode ? in_item.conic_xx : in_item.conic_yy;
  assign q_sel  = in_item.mode ? in_item.conic_xw : in_item.conic_yw;
  assign rq_sel = in_item.mode ? in_item.conic_yy : in_item.conic_xx;
  assign sq_sel = in_item.mode ? in_item.conic_yw : in_item.conic_xw;

  cli_mul #(.WA(DW), .WBB(DW), .SW(DW)) u_mul_bt (
    .clk, .rst_n, .en(fe), .in_vld(in_acc),
    .a(in_item.conic_xy), .b(in_item.line_coord), .side_in(q_sel),
    .out_vld(v1), .p(p_bt), .side_out(q_d)
  );

  cli_mul #(.WA(DW), .WBB(DW), .SW(DW)) u_mul_rt (
    .clk, .rst_n, .en(fe), .in_vld(in_acc),
    .a(rq_sel), .b(in_item.line_coord), .side_in(in_item.line_coord),
    .out_vld(), .p(p_rt), .side_out(t_d)
  );

  cli_mul #(.WA(DW), .WBB(DW), .SW(2*DW)) u_mul_st (
    .clk, .rst_n, .en(fe), .in_vld(in_acc),
    .a(sq_sel), .b(in_item.line_coord), .side_in({a_sel, in_item.conic_ww}),
    .out_vld(), .p(p_st), .side_out(s3_d)
  );

  assign b_c  = (WB'(p_bt) + (WB'($signed(q_d)) <<< FRAC_BITS)) <<< 1;
  assign cq_c = (WCQ'(p_st) <<< (FRAC_BITS + 1))
              + (WCQ'($signed(s3_d[DW-1:0])) <<< (2 * FRAC_BITS));

  cli_mul #(.WA(2*DW), .WBB(DW), .SW(S4W)) u_mul_rtt (
    .clk, .rst_n, .en(fe), .in_vld(v1),
    .a(p_rt), .b($signed(t_d)), .side_in({s3_d[2*DW-1:DW], b_c, cq_c}),
    .out_vld(v4), .p(p_rtt), .side_out(s4_d)
  );

  cli_mul #(.WA(WB), .WBB(WB), .SW(DW)) u_mul_bb (
    .clk, .rst_n, .en(fe), .in_vld(vc_r),
    .a(bc_r), .b(bc_r), .side_in(ac_r),
    .out_vld(), .p(bb), .side_out(s5_d)
  );

  cli_mul #(.WA(DW), .WBB(WC), .SW(WB)) u_mul_ac (
    .clk, .rst_n, .en(fe), .in_vld(vc_r),
    .a(ac_r), .b(c_r), .side_in(bc_r),
    .out_vld(v6), .p(ac), .side_out(s6_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (fe) begin
      vc_r <= v4;
      vd_r <= v6;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      c_r     <= WC'(p_rtt) + WC'($signed(s4_d[WCQ-1:0]));
      bc_r    <= $signed(s4_d[WCQ +: WB]);
      ac_r    <= $signed(s4_d[WCQ+WB +: DW]);
      disc_r  <= WDS'(bb) - (WDS'(ac) <<< 2);
      bd_r    <= $signed(s6_d);
      ad_r    <= $signed(s5_d);
      absd_r  <= disc_r[WDS-1] ? WDS'(-disc_r) : WDS'(disc_r);
      disce_r <= disc_r;
      be_r    <= bd_r;
      ae_r    <= ad_r;
    end
  end

  // round a tiny discriminant to zero, then classify
  assign thr_sh = WT'(thr) << (2 * FRAC_BITS);
  assign tiny   = WT'(absd_r) < thr_sh;

  assign mid_push = ve_r && !mid_full;
  assign mid_b    = be_r;
  assign mid_a    = ae_r;
  assign mid_disc = tiny ? '0 : disce_r;

  always_comb begin
    if (!tiny && disce_r[WDS-1]) begin
      mid_cls = ST_COMPLEX;
    end else if (ae_r == '0) begin
      mid_cls = ST_ZERO_A;
    end else begin
      mid_cls = ST_OK;
    end
  end

endmodule

// ----- sv/cli_back.sv -----
// Back half: pipelined square root, numerators, saturation test and two dividers.
// Takes classified items from the middle queue; uses cli_pkg.
module cli_back
  import cli_pkg::*;
#(
  parameter  int FRAC_BITS = 16,
  localparam int WB  = wb_w(FRAC_BITS),
  localparam int WDS = wds_w(FRAC_BITS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  mid_empty,
  input  logic signed [WB-1:0]  mid_b,
  input  logic signed [DW-1:0]  mid_a,
  input  logic signed [WDS-1:0] mid_disc,
  input  status_t               mid_cls,
  output logic                  mid_pop,
  input  logic                  out_full,
  output logic                  out_push,
  output cli_out_t              out_item
);

  localparam int WSQ = wsq_w(FRAC_BITS);
  localparam int WN  = wn_w(FRAC_BITS);
  localparam int WK  = imax(WN, 2 * DW + 1);

  logic                 be;

  // square root stages
  logic [WSQ:0]         vs_r;
  logic [WSQ+1:0]       rem_r  [WSQ+1];
  logic [WSQ-1:0]       root_r [WSQ+1];
  logic [2*WSQ-1:0]     op_r   [WSQ+1];
  logic signed [WB-1:0] sb_r   [WSQ+1];
  logic signed [DW-1:0] sa_r   [WSQ+1];
  status_t              sc_r   [WSQ+1];

  // numerator and magnitude stages
  logic                 vn_r, vm_r;
  logic signed [WN-1:0] n1_r, n2_r;
  logic signed [DW:0]   den_r;
  status_t              cn_r, cm_r;
  logic [WN-1:0]        mn1_r, mn2_r;
  logic [DW:0]          md_r;
  logic                 ng1_r, ng2_r;
  logic [WK-1:0]        lim1_c, lim2_c;

  // divider stages
  logic [DW:0]          vd_r;
  logic [DW:0]          dr1_r [DW+1];
  logic [DW:0]          dr2_r [DW+1];
  logic [DW-1:0]        dl1_r [DW+1];
  logic [DW-1:0]        dl2_r [DW+1];
  logic [DW-1:0]        dq1_r [DW+1];
  logic [DW-1:0]        dq2_r [DW+1];
  logic [DW:0]          dmd_r [DW+1];
  logic                 dng1_r [DW+1];
  logic                 dng2_r [DW+1];
  logic                 dsat1_r [DW+1];
  logic                 dsat2_r [DW+1];
  status_t              dc_r  [DW+1];

  logic [DW-1:0]        lim_p, lim_n, m1, m2;

  assign be      = !out_full || !vd_r[DW];
  assign mid_pop = be && !mid_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= '0;
      vn_r <= 1'b0;
      vm_r <= 1'b0;
      vd_r <= '0;
    end else if (be) begin
      vs_r <= {vs_r[WSQ-1:0], !mid_empty};
      vn_r <= vs_r[WSQ];
      vm_r <= vn_r;
      vd_r <= {vd_r[DW-1:0], vm_r};
    end
  end

  always_ff @(posedge clk) begin
    logic [WSQ+3:0] r2, trial;
    logic           ge;
    if (be) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      op_r[0]   <= (2*WSQ)'(mid_disc[WDS-2:0]);
      sb_r[0]   <= mid_b;
      sa_r[0]   <= mid_a;
      sc_r[0]   <= mid_cls;
      // one result bit per stage
      for (int i = 1; i <= WSQ; i++) begin
        r2    = {rem_r[i-1], op_r[i-1][2*WSQ-1 -: 2]};
        trial = (WSQ+4)'({root_r[i-1], 2'b01});
        ge    = (r2 >= trial);
        rem_r[i]  <= ge ? (WSQ+2)'(r2 - trial) : (WSQ+2)'(r2);
        root_r[i] <= {root_r[i-1][WSQ-2:0], ge};
        op_r[i]   <= op_r[i-1] << 2;
        sb_r[i]   <= sb_r[i-1];
        sa_r[i]   <= sa_r[i-1];
        sc_r[i]   <= sc_r[i-1];
      end
    end
  end

  assign lim1_c = (WK'(md_r) << (DW - 1)) + (ng1_r ? WK'(md_r) : '0);
  assign lim2_c = (WK'(md_r) << (DW - 1)) + (ng2_r ? WK'(md_r) : '0);

  always_ff @(posedge clk) begin
    logic [DW+1:0] t1, t2;
    logic          g1, g2;
    if (be) begin
      n1_r  <= -WN'(sb_r[WSQ]) + WN'($signed({1'b0, root_r[WSQ]}));
      n2_r  <= -WN'(sb_r[WSQ]) - WN'($signed({1'b0, root_r[WSQ]}));
      den_r <= (DW+1)'(sa_r[WSQ]) <<< 1;
      cn_r  <= sc_r[WSQ];

      mn1_r <= n1_r[WN-1] ? WN'(-n1_r) : WN'(n1_r);
      mn2_r <= n2_r[WN-1] ? WN'(-n2_r) : WN'(n2_r);
      md_r  <= den_r[DW] ? (DW+1)'(-den_r) : (DW+1)'(den_r);
      ng1_r <= n1_r[WN-1] ^ den_r[DW];
      ng2_r <= n2_r[WN-1] ^ den_r[DW];
      cm_r  <= cn_r;

      // quotient beyond the bound saturates; otherwise it fits DW bits
      dsat1_r[0] <= WK'(mn1_r) >= lim1_c;
      dsat2_r[0] <= WK'(mn2_r) >= lim2_c;
      dr1_r[0]   <= mn1_r[DW +: DW+1];
      dr2_r[0]   <= mn2_r[DW +: DW+1];
      dl1_r[0]   <= mn1_r[DW-1:0];
      dl2_r[0]   <= mn2_r[DW-1:0];
      dq1_r[0]   <= '0;
      dq2_r[0]   <= '0;
      dmd_r[0]   <= md_r;
      dng1_r[0]  <= ng1_r;
      dng2_r[0]  <= ng2_r;
      dc_r[0]    <= cm_r;

      for (int j = 1; j <= DW; j++) begin
        t1 = {dr1_r[j-1], dl1_r[j-1][DW-1]};
        t2 = {dr2_r[j-1], dl2_r[j-1][DW-1]};
        g1 = (t1 >= (DW+2)'(dmd_r[j-1]));
        g2 = (t2 >= (DW+2)'(dmd_r[j-1]));
        dr1_r[j]   <= g1 ? (DW+1)'(t1 - (DW+2)'(dmd_r[j-1])) : t1[DW:0];
        dr2_r[j]   <= g2 ? (DW+1)'(t2 - (DW+2)'(dmd_r[j-1])) : t2[DW:0];
        dl1_r[j]   <= dl1_r[j-1] << 1;
        dl2_r[j]   <= dl2_r[j-1] << 1;
        dq1_r[j]   <= {dq1_r[j-1][DW-2:0], g1};
        dq2_r[j]   <= {dq2_r[j-1][DW-2:0], g2};
        dmd_r[j]   <= dmd_r[j-1];
        dng1_r[j]  <= dng1_r[j-1];
        dng2_r[j]  <= dng2_r[j-1];
        dsat1_r[j] <= dsat1_r[j-1];
        dsat2_r[j] <= dsat2_r[j-1];
        dc_r[j]    <= dc_r[j-1];
      end
    end
  end

  assign lim_n = DW'(1) << (DW - 1);
  assign lim_p = lim_n - 1'b1;
  assign m1    = dsat1_r[DW] ? (dng1_r[DW] ? lim_n : lim_p) : dq1_r[DW];
  assign m2    = dsat2_r[DW] ? (dng2_r[DW] ? lim_n : lim_p) : dq2_r[DW];

  assign out_push = vd_r[DW] && be;

  always_comb begin
    out_item.root_plus  = '0;
    out_item.root_minus = '0;
    case (dc_r[DW])
      ST_COMPLEX: out_item.status = ST_COMPLEX;
      ST_ZERO_A:  out_item.status = ST_ZERO_A;
      default: begin
        out_item.root_plus  = dng1_r[DW] ? $signed(-m1) : $signed(m1);
        out_item.root_minus = dng2_r[DW] ? $signed(-m2) : $signed(m2);
        out_item.status     = (dsat1_r[DW] || dsat2_r[DW]) ? ST_SAT : ST_OK;
      end
    endcase
  end

endmodule

// ----- sv/conic_line_intersection.sv -----
// Conic/line intersection by the quadratic formula, signed fixed point.
// Input queue side: drive in_data and raise push; the item is taken at a clock edge
// with push high and full low. Result queue side: while empty is low the oldest
// result sits on out_data (root_plus, root_minus, status); pop with empty low takes it.
// cfg_we with cfg_wdata loads the discriminant zero threshold (unit 2^-2F) at any edge.
// Throughput: one item per cycle while full is low. A front pipeline builds a, b, c
// and the exact discriminant; a four-entry queue feeds the back pipeline with one stage
// per square root bit and one per quotient bit; the root has WSQ = wds_w(FRAC_BITS) / 2 bits.
// Reset (rst_n low, synchronous) empties every stage and queue and sets the threshold to 1.
// When the receiver stalls, the two-entry result queue fills, then the back pipeline
// holds, then the middle queue fills, then the front holds and full rises.
// Depends on cli_pkg, cli_mul, cli_fifo, cli_front and cli_back.
module conic_line_intersection
  import cli_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  cli_in_t          in_data,
  output logic             empty,
  input  logic             pop,
  output cli_out_t         out_data,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata
);

  localparam int WB  = wb_w(FRAC_BITS);
  localparam int WDS = wds_w(FRAC_BITS);
  localparam int MW  = 2 + DW + WB + WDS;
  localparam int OW  = $bits(cli_out_t);

  logic [THR_W-1:0]      thr_r;
  logic                  fe, in_acc;
  logic                  f_push, mid_full, mid_empty, mid_pop;
  logic signed [WB-1:0]  f_b, k_b;
  logic signed [DW-1:0]  f_a, k_a;
  logic signed [WDS-1:0] f_disc, k_disc;
  status_t               f_cls, k_cls;
  logic [1:0]            k_cls_raw;
  logic [MW-1:0]         mid_dout;
  logic                  o_push, out_full;
  cli_out_t              o_item;
  logic [OW-1:0]         out_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign full   = !fe;
  assign in_acc = push && fe;

  cli_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .in_acc, .in_item(in_data), .thr(thr_r), .mid_full,
    .fe, .mid_push(f_push), .mid_b(f_b), .mid_a(f_a), .mid_disc(f_disc), .mid_cls(f_cls)
  );

  cli_fifo #(.W(MW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk, .rst_n, .push(f_push), .din({f_cls, f_a, f_b, f_disc}),
    .pop(mid_pop), .dout(mid_dout), .full(mid_full), .empty(mid_empty)
  );

  assign {k_cls_raw, k_a, k_b, k_disc} = mid_dout;
  assign k_cls = status_t'(k_cls_raw);

  cli_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .mid_empty, .mid_b(k_b), .mid_a(k_a), .mid_disc(k_disc),
    .mid_cls(k_cls), .mid_pop, .out_full, .out_push(o_push), .out_item(o_item)
  );

  cli_fifo #(.W(OW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk, .rst_n, .push(o_push), .din(o_item),
    .pop, .dout(out_dout), .full(out_full), .empty
  );

  assign out_data = cli_out_t'(out_dout);

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for conic_line_intersection: queue-style driver and monitor,
// exact wide-integer prediction of both roots and the status. Depends on cli_pkg.
`timescale 1ns / 1ps
module tb;
  import cli_pkg::*;

  localparam int LATENCY   = 118;
  localparam int CYC_LIMIT = 400000;
  localparam int PHASE_N   = 300;

  logic             clk;
  logic             rst_n;
  logic             push;
  logic             full;
  cli_in_t          in_data;
  logic             empty;
  logic             pop;
  cli_out_t         out_data;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  conic_line_intersection uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  cli_in_t          pending_items[$];
  cli_out_t         expected_roots[$];
  logic [THR_W-1:0] zero_thr;
  int               errors;
  int               cycles;
  int               in_gap;
  int               out_gap;
  int               out_draw;
  int               hold_left;
  bit               hold_done;
  int               results_seen;
  logic             in_fire;
  logic             out_fire;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [255:0] isqrt_wide(input logic [255:0] v);
    logic [255:0] num, res, bitv;
    num  = v;
    res  = '0;
    bitv = 256'd1 << 254;
    for (int k = 0; k < 128; k++) begin
      if (num >= res + bitv) begin
        num = num - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Quotient truncated toward zero, clamped to the signed 32-bit range.
  function automatic logic [DW-1:0] root_div(input logic signed [255:0] n,
                                             input logic signed [255:0] d,
                                             inout bit sat);
    logic         neg;
    logic [255:0] mn, md, q, lim;
    neg = n[255] ^ d[255];
    mn  = n[255] ? -n : n;
    md  = d[255] ? -d : d;
    q   = mn / md;
    lim = (256'd1 << (DW - 1)) - (neg ? 256'd0 : 256'd1);
    if (q > lim) begin
      q   = lim;
      sat = 1'b1;
    end
    return neg ? -q[DW-1:0] : q[DW-1:0];
  endfunction

  function automatic cli_out_t solve_line(input cli_in_t it, input logic [THR_W-1:0] thr_v);
    logic signed [255:0] cxx, cxy, cxw, cyy, cyw, cww, t, a, q, rq, sq, b, c, disc, ad, thr;
    logic signed [255:0] s;
    bit                  sat;
    cli_out_t            r;
    cxx = it.conic_xx; cxy = it.conic_xy; cxw = it.conic_xw;
    cyy = it.conic_yy; cyw = it.conic_yw; cww = it.conic_ww;
    t   = it.line_coord;
    a   = it.mode ? cxx : cyy;
    q   = it.mode ? cxw : cyw;
    rq  = it.mode ? cyy : cxx;
    sq  = it.mode ? cyw : cxw;
    b    = (cxy * t + (q <<< 16)) <<< 1;
    c    = rq * t * t + ((sq * t) <<< 17) + (cww <<< 32);
    disc = b * b - ((a * c) <<< 2);
    thr  = {224'd0, thr_v};
    thr  = thr <<< 32;
    ad   = disc[255] ? -disc : disc;
    if ($unsigned(ad) < $unsigned(thr)) disc = '0;
    r.root_plus  = '0;
    r.root_minus = '0;
    sat = 1'b0;
    if (disc[255]) begin
      r.status = ST_COMPLEX;
    end else if (a == 0) begin
      r.status = ST_ZERO_A;
    end else begin
      s            = isqrt_wide(disc);
      r.root_plus  = root_div(-b + s, a <<< 1, sat);
      r.root_minus = root_div(-b - s, a <<< 1, sat);
      r.status     = sat ? ST_SAT : ST_OK;
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] rand_coef();
    logic signed [DW-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return v;
      default: return v >>> $urandom_range(6, 28);
    endcase
  endfunction

  task automatic add_item(input logic m, input logic signed [DW-1:0] xx, xy, xw, yy, yw, ww,
                          input logic signed [DW-1:0] t);
    cli_in_t it;
    it = '{mode: m, conic_xx: xx, conic_xy: xy, conic_xw: xw, conic_yy: yy,
           conic_yw: yw, conic_ww: ww, line_coord: t};
    pending_items.push_back(it);
  endtask

  task automatic add_random(input int n);
    cli_in_t it;
    for (int i = 0; i < n; i++) begin
      it.mode       = $urandom_range(0, 1);
      it.conic_xx   = rand_coef();
      it.conic_xy   = rand_coef();
      it.conic_xw   = rand_coef();
      it.conic_yy   = rand_coef();
      it.conic_yw   = rand_coef();
      it.conic_ww   = rand_coef();
      it.line_coord = rand_coef();
      pending_items.push_back(it);
    end
  endtask

  task automatic drain_and_write(input logic [THR_W-1:0] v);
    wait (pending_items.size() == 0 && !push && expected_roots.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    zero_thr  = v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sender: hold the item until taken, then wait a drawn gap.
  always @(posedge clk) in_fire <= push && !full;

  always @(posedge clk) out_fire <= pop && !empty;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        expected_roots.push_back(solve_line(pending_items[0], zero_thr));
        void'(pending_items.pop_front());
      end
      if (in_fire || !push) begin
        if (in_gap > 0 && !(in_fire && pending_items.size() > 0 && in_gap == 0)) begin
          push   <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items[0];
          push    <= 1'b1;
          in_gap  <= ((cycles / 2000) % 3 == 0) ? 0 : $urandom_range(0, 11);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: check every popped result against the oldest expectation.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_n && pop && !empty) begin
      results_seen <= results_seen + 1;
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors = errors + 1;
      end else begin
        if (out_data.root_plus !== expected_roots[0].root_plus) begin
          $display("%0t: root_plus expected %h actual %h", $time,
                   expected_roots[0].root_plus, out_data.root_plus);
          errors = errors + 1;
        end
        if (out_data.root_minus !== expected_roots[0].root_minus) begin
          $display("%0t: root_minus expected %h actual %h", $time,
                   expected_roots[0].root_minus, out_data.root_minus);
          errors = errors + 1;
        end
        if (out_data.status !== expected_roots[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   expected_roots[0].status, out_data.status);
          errors = errors + 1;
        end
        void'(expected_roots.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && results_seen == 20) begin
        // long hold-off so the block backs up to its input
        hold_done <= 1'b1;
        hold_left <= 2000;
        pop       <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else if (out_fire) begin
        out_draw = ((cycles / 1500) % 3 == 1) ? 0 : $urandom_range(0, 11);
        out_gap  <= (out_draw > 0) ? out_draw - 1 : 0;
        pop      <= (out_draw == 0);
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        pop     <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    zero_thr     = 32'd1;
    errors       = 0;
    cycles       = 0;
    in_gap       = 0;
    out_gap      = 0;
    out_draw     = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    results_seen = 0;
    in_fire      = 1'b0;
    out_fire     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // circle of radius 1: secant, tangent, miss, near tangent; then extreme and degenerate cases
    for (int m = 0; m < 2; m++) begin
      add_item(1'(m), 32'sh10000, 0, 0, 32'sh10000, 0, -32'sh10000, 0);
      add_item(1'(m), 32'sh10000, 0, 0, 32'sh10000, 0, -32'sh10000, 32'sh10000);
      add_item(1'(m), 32'sh10000, 0, 0, 32'sh10000, 0, -32'sh10000, 32'sh20000);
      add_item(1'(m), 32'sh10000, 0, 0, 32'sh10000, 0, -32'sh10000, 32'shFFFF);
      add_item(1'(m), 1, 0, 0, 1, 0, -32'sh10000, 0);
      add_item(1'(m), 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
               32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      add_item(1'(m), 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
               32'sh80000000, 32'sh80000000, 32'sh80000000);
      add_item(1'(m), 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
               32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
      add_item(1'(m), 0, 0, 0, 0, 0, 0, 0);
      add_item(1'(m), 0, 32'sh10000, 32'sh10000, 0, 32'sh10000, -32'sh10000, 32'sh8000);
      add_item(1'(m), -32'sh10000, 32'sh4000, 0, -32'sh10000, 0, 32'sh40000, -32'sh18000);
    end
    add_random(PHASE_N);
    drain_and_write(32'd0);
    add_random(PHASE_N);
    drain_and_write(32'hFFFFFFFF);
    add_random(PHASE_N);
    drain_and_write($urandom);
    add_random(PHASE_N / 2);
    drain_and_write(32'd1);
    add_random(PHASE_N / 2);

    wait (pending_items.size() == 0 && !push && expected_roots.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
